// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the list core checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- rtl/ilid_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed list package
// Shared constants, codes and the cell control bundle of the list core.
// ----------------------------------------------------------------------------
package ilid_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 4;
    localparam int COUNT_W      = 5;
    localparam int SCAN_W       = 8;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_GET    = 3'd2,
        ACT_FIND   = 3'd3,
        ACT_APPEND = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_APPEND,
        CELL_COMPARE,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   value;
    } cell_ctl_t;

    typedef enum logic {
        S_RUN,
        S_SCAN
    } ilid_state_t;

endpackage

// ----- rtl/ilid_cell.sv -----
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry and its match flag; shifts with its neighbors.
// ----------------------------------------------------------------------------
module ilid_cell #(
    parameter int CAPACITY = ilid_pkg::DEF_CAPACITY,
    parameter int CELL_IDX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ilid_pkg::cell_ctl_t               ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]     pos,
    input  logic [$clog2(CAPACITY+1)-1:0]     length,
    input  logic [ilid_pkg::DATA_W-1:0]       left_entry,
    input  logic [ilid_pkg::DATA_W-1:0]       right_entry,
    input  logic                              match_in,
    output logic [ilid_pkg::DATA_W-1:0]       entry,
    output logic                              match
);

    localparam int LW = $clog2(CAPACITY+1);
    localparam logic [LW-1:0] IDX    = LW'(CELL_IDX);
    localparam logic [LW-1:0] IDX_P1 = LW'(CELL_IDX + 1);

    logic [ilid_pkg::DATA_W-1:0] entry_reg;
    logic [ilid_pkg::DATA_W-1:0] entry_next;
    logic                        match_reg;
    logic                        match_next;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        case (ctl.op)
            ilid_pkg::CELL_INSERT:
            begin
                if (IDX == pos)
                begin
                    entry_next = ctl.value;
                end
                else if ((IDX > pos) && (IDX <= length))
                begin
                    entry_next = left_entry;
                end
            end
            ilid_pkg::CELL_DELETE:
            begin
                if ((IDX >= pos) && (IDX_P1 < length))
                begin
                    entry_next = right_entry;
                end
            end
            ilid_pkg::CELL_APPEND:
            begin
                if (IDX == length)
                begin
                    entry_next = ctl.value;
                end
            end
            ilid_pkg::CELL_COMPARE:
            begin
                match_next = (entry_reg == ctl.value) && (IDX < length);
            end
            ilid_pkg::CELL_SHIFT:
            begin
                match_next = match_in;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// ----- rtl/indexed_list_insert_delete_core.sv -----
// ----------------------------------------------------------------------------
// Indexed list core
// Fixed-capacity ordered list of signed words kept in a row of cells.
// ----------------------------------------------------------------------------
// Insert, delete, get and append complete on acceptance, so a new item can be
// accepted every cycle while the result register is free and no find scans;
// the cells behind the position move their entries to a neighbor in parallel.
// Find compares all cells in the accept cycle, then the match flags shift
// toward the head eight places per cycle through a priority encoder, and the
// scan ends at the first group of eight that holds a match or at the list end.
// A stalled result register holds the finished scan until it frees.
module indexed_list_insert_delete_core #(
    parameter int CAPACITY = ilid_pkg::DEF_CAPACITY
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [2:0]                           action,
    input  logic [ilid_pkg::POS_W-1:0]           position,
    input  logic signed [ilid_pkg::DATA_W-1:0]   value,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [1:0]                           status,
    output logic signed [ilid_pkg::DATA_W-1:0]   read_value,
    output logic [ilid_pkg::POS_W-1:0]           found_at,
    output logic [ilid_pkg::COUNT_W-1:0]         count
);

    localparam int LW   = $clog2(CAPACITY+1);
    localparam int PW   = ilid_pkg::POS_W;
    localparam int CNW  = ilid_pkg::COUNT_W;
    localparam int DW   = ilid_pkg::DATA_W;
    localparam int SW   = ilid_pkg::SCAN_W;
    localparam int CMPW = (LW > PW) ? LW : PW;
    localparam int NGET = (CAPACITY < (1 << PW)) ? CAPACITY : (1 << PW);
    localparam int GIW  = $clog2(NGET);
    localparam int NWIN = (CAPACITY < SW) ? CAPACITY : SW;
    localparam int WIW  = $clog2(NWIN);

    ilid_pkg::ilid_state_t state_reg;
    ilid_pkg::ilid_state_t state_next;
    logic [LW-1:0]         length_reg;
    logic [LW-1:0]         length_next;
    logic [LW-1:0]         base_reg;
    logic [LW-1:0]         base_next;

    logic                  res_valid_reg;
    logic                  res_valid_next;
    ilid_pkg::status_t     status_reg;
    ilid_pkg::status_t     status_next;
    logic [DW-1:0]         read_value_reg;
    logic [DW-1:0]         read_value_next;
    logic [PW-1:0]         found_reg;
    logic [PW-1:0]         found_next;
    logic [CNW-1:0]        count_reg;
    logic [CNW-1:0]        count_next;

    ilid_pkg::cell_ctl_t   ctl;
    logic [DW-1:0]         entry [CAPACITY];
    logic [DW-1:0]         get_tap [NGET];
    logic [CAPACITY-1:0]   match;

    logic                  out_free;
    logic                  accept;
    logic                  load_out;
    logic [CMPW-1:0]       pos_c;
    logic [CMPW-1:0]       len_c;
    logic [CMPW:0]         base_sum;
    logic [CMPW-1:0]       found_sum;
    logic                  win_hit;
    logic [WIW-1:0]        win_idx;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DW-1:0] left_entry;
            logic [DW-1:0] right_entry;
            logic          match_in;

            if (gi == 0)
            begin : g_head
                assign left_entry = '0;
            end
            else
            begin : g_left
                assign left_entry = entry[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_right
                assign right_entry = entry[gi+1];
            end

            if (gi + SW < CAPACITY)
            begin : g_scan
                assign match_in = match[gi+SW];
            end
            else
            begin : g_scan_end
                assign match_in = 1'b0;
            end

            ilid_cell #(
                .CAPACITY (CAPACITY),
                .CELL_IDX (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .pos         (LW'(position)),
                .length      (length_reg),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .match_in    (match_in),
                .entry       (entry[gi]),
                .match       (match[gi])
            );
        end

        for (gi = 0; gi < NGET; gi++)
        begin : g_get
            assign get_tap[gi] = entry[gi];
        end
    endgenerate

    assign out_free   = !res_valid_reg || !result_stall;
    assign item_stall = !((state_reg == ilid_pkg::S_RUN) && out_free);
    assign accept     = item_valid && !item_stall;
    assign pos_c      = CMPW'(position);
    assign len_c      = CMPW'(length_reg);
    assign base_sum   = (CMPW+1)'(base_reg) + (CMPW+1)'(SW);
    assign found_sum  = CMPW'(base_reg) + CMPW'(win_idx);

    always_comb
    begin
        win_hit = 1'b0;
        win_idx = '0;
        for (int k = NWIN - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                win_hit = 1'b1;
                win_idx = WIW'(k);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        length_next     = length_reg;
        base_next       = base_reg;
        ctl.op          = ilid_pkg::CELL_HOLD;
        ctl.value       = value;
        load_out        = 1'b0;
        status_next     = ilid_pkg::ST_OK;
        read_value_next = '0;
        found_next      = '0;

        case (state_reg)
            ilid_pkg::S_RUN:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (action)
                        ilid_pkg::ACT_INSERT:
                        begin
                            if (pos_c > len_c)
                            begin
                                status_next = ilid_pkg::ST_RANGE;
                            end
                            else if (len_c >= CMPW'(CAPACITY))
                            begin
                                status_next = ilid_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.op      = ilid_pkg::CELL_INSERT;
                                length_next = length_reg + LW'(1);
                            end
                        end
                        ilid_pkg::ACT_DELETE:
                        begin
                            if (pos_c >= len_c)
                            begin
                                status_next = ilid_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ctl.op      = ilid_pkg::CELL_DELETE;
                                length_next = length_reg - LW'(1);
                            end
                        end
                        ilid_pkg::ACT_GET:
                        begin
                            if (pos_c >= len_c)
                            begin
                                status_next = ilid_pkg::ST_RANGE;
                            end
                            else
                            begin
                                read_value_next = get_tap[position[GIW-1:0]];
                            end
                        end
                        ilid_pkg::ACT_FIND:
                        begin
                            load_out   = 1'b0;
                            ctl.op     = ilid_pkg::CELL_COMPARE;
                            base_next  = '0;
                            state_next = ilid_pkg::S_SCAN;
                        end
                        ilid_pkg::ACT_APPEND:
                        begin
                            if (len_c >= CMPW'(CAPACITY))
                            begin
                                status_next = ilid_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.op      = ilid_pkg::CELL_APPEND;
                                length_next = length_reg + LW'(1);
                            end
                        end
                        default:
                        begin
                            status_next = ilid_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ilid_pkg::S_SCAN:
            begin
                if (win_hit)
                begin
                    found_next = PW'(found_sum);
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ilid_pkg::S_RUN;
                    end
                end
                else if (base_sum >= (CMPW+1)'(length_reg))
                begin
                    status_next = ilid_pkg::ST_NOTFOUND;
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ilid_pkg::S_RUN;
                    end
                end
                else
                begin
                    ctl.op    = ilid_pkg::CELL_SHIFT;
                    base_next = LW'(base_sum);
                end
            end
            default:
            begin
                state_next = ilid_pkg::S_RUN;
            end
        endcase

        count_next = CNW'(length_next);

        if (load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ilid_pkg::S_RUN;
            length_reg    <= '0;
            base_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            base_reg      <= base_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            found_reg      <= found_next;
            count_reg      <= count_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign read_value   = read_value_reg;
    assign found_at     = found_reg;
    assign count        = count_reg;

endmodule

// ----- rtl/ilid_checker.sv -----
// ----------------------------------------------------------------------------
// Indexed list checker
// Port-level checks on the results of the list core, bound into the core module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ilid_checker #(
    parameter int CAPACITY = ilid_pkg::DEF_CAPACITY
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 result_valid,
    input logic                                 result_stall,
    input logic [1:0]                           status,
    input logic signed [ilid_pkg::DATA_W-1:0]   read_value,
    input logic [ilid_pkg::POS_W-1:0]           found_at,
    input logic [ilid_pkg::COUNT_W-1:0]         count
);

    localparam int CNW = ilid_pkg::COUNT_W;

    `ASSERT_SYNC(a_count_bound, clk, rst_n,
        result_valid |-> ((CAPACITY > 31) || (count <= CNW'(CAPACITY))))

    `ASSERT_SYNC(a_full_count, clk, rst_n,
        (result_valid && (status == ilid_pkg::ST_FULL)) |-> (count == CNW'(CAPACITY)))

    `ASSERT_SYNC(a_error_zero, clk, rst_n,
        (result_valid && (status != ilid_pkg::ST_OK))
            |-> ((read_value == '0) && (found_at == '0)))

    `ASSERT_SYNC(a_result_hold, clk, rst_n,
        (result_valid && result_stall) |=> (result_valid && $stable(status) && $stable(count)))

endmodule

bind indexed_list_insert_delete_core ilid_checker #(.CAPACITY(CAPACITY)) u_ilid_checker (.*);
